[sv/gems_pkg.sv]
`default_nettype none

package gems_pkg;

    // input item kinds, carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_LOAD_DISC = 2'd0,
        OP_PIXEL     = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_NONE      = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [2:0] REG_IMAGE_ROWS   = 3'd0;
    localparam logic [2:0] REG_IMAGE_COLS   = 3'd1;
    localparam logic [2:0] REG_DISC_ROWS    = 3'd2;
    localparam logic [2:0] REG_DISC_COLS    = 3'd3;
    localparam logic [2:0] REG_SAMPLE_LIMIT = 3'd4;

    // register reset values
    localparam logic [8:0]  RST_IMAGE_ROWS   = 9'd256;
    localparam logic [8:0]  RST_IMAGE_COLS   = 9'd256;
    localparam logic [4:0]  RST_DISC_ROWS    = 5'd1;
    localparam logic [4:0]  RST_DISC_COLS    = 5'd1;
    localparam logic [15:0] RST_SAMPLE_LIMIT = 16'hFFFF;

    // last step of the two-bit-per-cycle divider (18 dividend bits)
    localparam logic [3:0] DIV_LAST_STEP = 4'd8;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_LOOK,
        ST_CHECK,
        ST_STAMP,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

[sv/greedy_exclusion_mask_sampler.sv]
// channel      dir  handshake                      payload
// s_axis       in   s_axis_tvalid / s_axis_tready  tuser op, tdata pixel / disc row
// m_axis       out  m_axis_tvalid / m_axis_tready  tdata sample, tlast limit reached
// wr           in   wr_en (no wait)                wr_index, wr_data
//
// a pixel passes through an accept in the idle state, the two-bit restoring divider, one mask read,
// one check and, when not masked, one read-modify-write of the mask memory per disc row inside
// the image, plus a drain of the last write
// disc loads and unknown kinds are done at accept; pixels out of range or past the limit too
// after reset and after a clear item the mask memory is swept one row a cycle over all
// MAX_ROWS rows, during which no item is accepted
// a taken pixel waits in the check state while the output register still holds a result
`default_nettype none

module greedy_exclusion_mask_sampler #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256,
    parameter int DISC_MAX = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [16:0] pixel_index, [20:17] disc_row_number, [36:21] disc_row_bits, [39:37] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] sample_row, [15:8] sample_col, [31:16] sample_number
    output logic [31:0]      m_axis_tdata,
    // last
    output logic             m_axis_tlast,

    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data
);

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int DMAX = (DISC_MAX < 16) ? DISC_MAX : 16;
    localparam int DAW  = (DISC_MAX > 1) ? $clog2(DISC_MAX) : 1;
    localparam int EXW  = MAX_COLS + 16;

    // configuration registers
    logic [8:0]  image_rows_reg;
    logic [8:0]  image_cols_reg;
    logic [4:0]  disc_rows_reg;
    logic [4:0]  disc_cols_reg;
    logic [15:0] sample_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_rows_reg   <= gems_pkg::RST_IMAGE_ROWS;
            image_cols_reg   <= gems_pkg::RST_IMAGE_COLS;
            disc_rows_reg    <= gems_pkg::RST_DISC_ROWS;
            disc_cols_reg    <= gems_pkg::RST_DISC_COLS;
            sample_limit_reg <= gems_pkg::RST_SAMPLE_LIMIT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                gems_pkg::REG_IMAGE_ROWS:   image_rows_reg   <= wr_data[8:0];
                gems_pkg::REG_IMAGE_COLS:   image_cols_reg   <= wr_data[8:0];
                gems_pkg::REG_DISC_ROWS:    disc_rows_reg    <= wr_data[4:0];
                gems_pkg::REG_DISC_COLS:    disc_cols_reg    <= wr_data[4:0];
                gems_pkg::REG_SAMPLE_LIMIT: sample_limit_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // saturated geometry
    logic [8:0] rows_c;
    logic [8:0] cols_c;
    logic [4:0] dh;
    logic [4:0] dw;
    logic [3:0] half_h;
    logic [3:0] half_w;
    logic [15:0] dw_mask;
    logic [MAX_COLS-1:0] col_mask;

    always_comb
    begin
        if (image_rows_reg == 9'd0)
            rows_c = 9'd1;
        else if (32'(image_rows_reg) > MAX_ROWS)
            rows_c = 9'(MAX_ROWS);
        else
            rows_c = image_rows_reg;

        if (image_cols_reg == 9'd0)
            cols_c = 9'd1;
        else if (32'(image_cols_reg) > MAX_COLS)
            cols_c = 9'(MAX_COLS);
        else
            cols_c = image_cols_reg;

        if (disc_rows_reg == 5'd0)
            dh = 5'd1;
        else if (32'(disc_rows_reg) > DMAX)
            dh = 5'(DMAX);
        else
            dh = disc_rows_reg;

        if (disc_cols_reg == 5'd0)
            dw = 5'd1;
        else if (32'(disc_cols_reg) > DMAX)
            dw = 5'(DMAX);
        else
            dw = disc_cols_reg;

        half_h  = 4'((6'(dh) + 6'd1) >> 1);
        half_w  = 4'((6'(dw) + 6'd1) >> 1);
        dw_mask = 16'((17'd1 << dw) - 17'd1);

        for (int k = 0; k < MAX_COLS; k++)
            col_mask[k] = (32'(k) < 32'(cols_c));
    end

    // input fields
    logic [1:0]  in_op;
    logic [16:0] in_index;
    logic [3:0]  in_disc_row;
    logic [15:0] in_disc_bits;
    logic [16:0] idx_m1;
    logic [17:0] pixel_total;
    logic        idx_bad;
    logic        limit_hit;

    assign in_op        = s_axis_tuser;
    assign in_index     = s_axis_tdata[16:0];
    assign in_disc_row  = s_axis_tdata[20:17];
    assign in_disc_bits = s_axis_tdata[36:21];
    assign idx_m1       = in_index - 17'd1;
    assign pixel_total  = rows_c * cols_c;
    assign idx_bad      = (in_index == 17'd0) || ({1'b0, idx_m1} >= pixel_total);

    // state
    gems_pkg::state_t state_reg, state_next;
    logic [RW-1:0]  clr_cnt_reg;
    logic [17:0]    dvd_reg;
    logic [8:0]     rem_reg;
    logic [8:0]     quot_reg;
    logic [3:0]     div_cnt_reg;
    logic [4:0]     st_cnt_reg;
    logic           st_wr_reg;
    logic [RW-1:0]  st_row_reg;
    logic [15:0]    taken_count_reg;
    logic           out_valid_reg;
    logic [7:0]     out_row_reg;
    logic [7:0]     out_col_reg;
    logic [15:0]    out_num_reg;
    logic           out_last_reg;

    assign limit_hit = (taken_count_reg >= sample_limit_reg);

    // divider step: two restoring subtractions per cycle
    logic [9:0] t1, t2;
    logic       q1, q2;
    logic [8:0] r1, r2;

    always_comb
    begin
        t1 = {rem_reg, dvd_reg[17]};
        q1 = (t1 >= {1'b0, rows_c});
        r1 = q1 ? 9'(t1 - {1'b0, rows_c}) : t1[8:0];
        t2 = {r1, dvd_reg[16]};
        q2 = (t2 >= {1'b0, rows_c});
        r2 = q2 ? 9'(t2 - {1'b0, rows_c}) : t2[8:0];
    end

    // disc row being issued during the stamp
    logic signed [10:0] ir;
    logic               ir_ok;

    assign ir    = $signed({2'b00, rem_reg}) - $signed({7'd0, half_h})
                 + $signed({6'd0, st_cnt_reg});
    assign ir_ok = !ir[10] && (ir[9:0] < {1'b0, rows_c});

    // memories
    logic [MAX_COLS-1:0] mask_mem [MAX_ROWS];
    logic [15:0]         pat_mem  [DISC_MAX];
    logic [MAX_COLS-1:0] mask_rdata_reg;
    logic [15:0]         pat_rdata_reg;

    logic                mem_re;
    logic [RW-1:0]       mem_raddr;
    logic                mem_we;
    logic [RW-1:0]       mem_waddr;
    logic [MAX_COLS-1:0] mem_wdata;
    logic                pat_re;
    logic                pat_we;
    logic                out_load;
    logic                hit;

    // placement of the disc row into the image row
    logic [9:0]          col_shift;
    logic [EXW-1:0]      disc_ext;
    logic [MAX_COLS-1:0] stamp_bits;

    always_comb
    begin
        col_shift  = 10'(quot_reg) + 10'd16 - {6'd0, half_w};
        disc_ext   = EXW'(pat_rdata_reg & dw_mask) << col_shift;
        stamp_bits = disc_ext[EXW-1:16] & col_mask;
    end

    assign hit = mask_rdata_reg[CW'(quot_reg)];

    // write port: clearing sweep or stamp write-back
    always_comb
    begin
        if (state_reg == gems_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = st_wr_reg;
            mem_waddr = st_row_reg;
            mem_wdata = mask_rdata_reg | stamp_bits;
        end
    end

    // next state and control
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        mem_re        = 1'b0;
        mem_raddr     = RW'(rem_reg);
        pat_re        = 1'b0;
        pat_we        = 1'b0;
        out_load      = 1'b0;

        case (state_reg)
            gems_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == RW'(MAX_ROWS - 1))
                    state_next = gems_pkg::ST_IDLE;
            end
            gems_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    case (in_op)
                        gems_pkg::OP_LOAD_DISC:
                            pat_we = (32'(in_disc_row) < DISC_MAX);
                        gems_pkg::OP_PIXEL:
                        begin
                            if (!idx_bad && !limit_hit)
                                state_next = gems_pkg::ST_DIV;
                        end
                        gems_pkg::OP_CLEAR:
                            state_next = gems_pkg::ST_CLEAR;
                        default: ;
                    endcase
                end
            end
            gems_pkg::ST_DIV:
            begin
                if (div_cnt_reg == gems_pkg::DIV_LAST_STEP)
                    state_next = gems_pkg::ST_LOOK;
            end
            gems_pkg::ST_LOOK:
            begin
                mem_re     = 1'b1;
                mem_raddr  = RW'(rem_reg);
                state_next = gems_pkg::ST_CHECK;
            end
            gems_pkg::ST_CHECK:
            begin
                if (hit)
                    state_next = gems_pkg::ST_IDLE;
                else if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = gems_pkg::ST_STAMP;
                end
            end
            gems_pkg::ST_STAMP:
            begin
                mem_re    = ir_ok;
                mem_raddr = RW'(ir[8:0]);
                pat_re    = 1'b1;
                if (st_cnt_reg == dh - 5'd1)
                    state_next = gems_pkg::ST_DRAIN;
            end
            gems_pkg::ST_DRAIN:
                state_next = gems_pkg::ST_IDLE;
            default:
                state_next = gems_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= gems_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            div_cnt_reg     <= '0;
            st_cnt_reg      <= '0;
            st_wr_reg       <= 1'b0;
            taken_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            st_wr_reg <= (state_reg == gems_pkg::ST_STAMP) && ir_ok;

            if (state_reg == gems_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + RW'(1);

            if (state_reg == gems_pkg::ST_IDLE && s_axis_tvalid)
            begin
                div_cnt_reg <= '0;
                if (in_op == gems_pkg::OP_CLEAR)
                begin
                    clr_cnt_reg     <= '0;
                    taken_count_reg <= '0;
                end
            end

            if (state_reg == gems_pkg::ST_DIV)
                div_cnt_reg <= div_cnt_reg + 4'd1;

            if (state_reg == gems_pkg::ST_STAMP)
                st_cnt_reg <= st_cnt_reg + 5'd1;

            if (out_load)
            begin
                taken_count_reg <= taken_count_reg + 16'd1;
                st_cnt_reg      <= '0;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == gems_pkg::ST_IDLE && s_axis_tvalid)
        begin
            dvd_reg  <= {1'b0, idx_m1};
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (state_reg == gems_pkg::ST_DIV)
        begin
            dvd_reg  <= {dvd_reg[15:0], 2'b00};
            rem_reg  <= r2;
            quot_reg <= {quot_reg[6:0], q1, q2};
        end

        if (state_reg == gems_pkg::ST_STAMP)
            st_row_reg <= RW'(ir[8:0]);

        if (out_load)
        begin
            out_row_reg  <= rem_reg[7:0];
            out_col_reg  <= quot_reg[7:0];
            out_num_reg  <= taken_count_reg;
            out_last_reg <= ((17'(taken_count_reg) + 17'd1) == 17'(sample_limit_reg));
        end
    end

    // mask memory, one row per word
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mask_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mask_rdata_reg <= mask_mem[mem_raddr];
    end

    // disc pattern memory
    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[DAW'(in_disc_row)] <= in_disc_bits;
        if (pat_re)
            pat_rdata_reg <= pat_mem[DAW'(st_cnt_reg)];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_num_reg, out_col_reg, out_row_reg};
    assign m_axis_tlast  = out_last_reg;

    // the stamp never reads the row it is writing back in the same cycle
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("mask read and write hit the same row");

    // a clearing sweep never coincides with a pending stamp write
    a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gems_pkg::ST_CLEAR) |-> !st_wr_reg)
        else $error("stamp write pending during clearing sweep");

    // the divider leaves a remainder below the row count
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gems_pkg::ST_LOOK) |-> (rem_reg < rows_c))
        else $error("divider remainder out of range");

    // a new result only comes from the check state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == gems_pkg::ST_CHECK))
        else $error("result appeared outside the check state");

    // the count moves only by a taken pixel or a clear
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (taken_count_reg != $past(taken_count_reg))
            |-> ($past(out_load) || taken_count_reg == 16'd0))
        else $error("taken count changed without a transfer");

endmodule

`default_nettype wire
